// ----- rtl/rrts_pkg.sv -----
// Shared types and constants for the round-robin task scheduler.
`default_nettype none
package rrts_pkg;

    localparam int TASK_SLOTS_DEF      = 8;
    localparam int MUTEX_SLOTS_DEF     = 4;
    localparam int SEMAPHORE_SLOTS_DEF = 4;

    localparam logic [7:0] SEM_MAX   = 8'hFF;
    localparam int         NO_OWNER  = 15;

    typedef enum logic [1:0] {
        ST_READY      = 2'd0,
        ST_RUNNING    = 2'd1,
        ST_BLOCKED    = 2'd2,
        ST_MUTEX_WAIT = 2'd3
    } task_state_t;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_DELAY  = 3'd1,
        OP_LOCK   = 3'd2,
        OP_UNLOCK = 3'd3,
        OP_WAIT   = 3'd4,
        OP_POST   = 3'd5
    } op_code_t;

    // Command broadcast to every task cell.
    typedef struct packed {
        logic        tick;
        logic [31:0] now;
        logic        unlock;
        logic        post;
        logic        cur_wr;
        task_state_t cur_val;
        logic        release_cur;
        logic        wake_wr;
        logic [31:0] wake_val;
        logic        run;
    } cell_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/round_robin_task_scheduler_unit.sv -----
// Top level of the round-robin task scheduler with its sequencer and sync objects.
`default_nettype none
// Each transfer on the input stream is one scheduler operation and yields exactly one
// result transfer. Task states live in a row of cells; a post wakes the lowest blocked
// task through a carry that ripples along the row. An operation without a scheduling
// pass goes from the execute state straight to the done state. A pass first reduces
// the successor index modulo the task count (one subtract per cycle), then probes
// one candidate per cycle, up to n candidates. A new input is taken once the previous
// one is finished; its result may still sit in the output register waiting for the
// consumer.
module round_robin_task_scheduler_unit
    import rrts_pkg::*;
#(
    parameter int TASK_SLOTS      = TASK_SLOTS_DEF,
    parameter int MUTEX_SLOTS     = MUTEX_SLOTS_DEF,
    parameter int SEMAPHORE_SLOTS = SEMAPHORE_SLOTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_wr_data,    // task_count
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // operation[2:0], delay_ticks[34:3],
                                             // object_index[36:35], zero fill
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata    // chosen_task[2:0], switch_request[3],
                                             // granted[4], zero fill
);

    localparam int TW    = $clog2(TASK_SLOTS);
    localparam int NW    = $clog2(TASK_SLOTS + 1);
    localparam int OWN_W = (TW > 4) ? TW : 4;
    localparam int MIDX  = (MUTEX_SLOTS > 1) ? $clog2(MUTEX_SLOTS) : 1;
    localparam int SIDX  = (SEMAPHORE_SLOTS > 1) ? $clog2(SEMAPHORE_SLOTS) : 1;

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MOD, S_SCAN, S_DONE} fsm_t;

    fsm_t              state_reg;
    logic [3:0]        task_count_reg;
    logic [2:0]        op_reg;
    logic [31:0]       dly_reg;
    logic [1:0]        obj_reg;
    logic [31:0]       counter_reg;
    logic [TW-1:0]     running_reg;
    logic [TW:0]       cand_reg;
    logic [NW-1:0]     left_reg;
    logic              sw_reg, gr_reg;
    logic              m_valid_reg;
    logic [7:0]        m_data_reg;
    logic              locked_reg [MUTEX_SLOTS];
    logic [OWN_W-1:0]  owner_reg  [MUTEX_SLOTS];
    logic [7:0]        sem_reg    [SEMAPHORE_SLOTS];

    cell_cmd_t         cmd;
    task_state_t       cell_state [TASK_SLOTS];
    logic [TASK_SLOTS:0] blk_chain;
    logic [NW-1:0]     n_eff;
    logic              pass, grant;
    logic              m_ok, s_ok;
    logic [MIDX-1:0]   m_idx;
    logic [SIDX-1:0]   s_idx;
    logic              cand_ready, scan_last;
    logic [TW-1:0]     sel_idx;

    assign n_eff = (task_count_reg == 4'd0) ? NW'(1) :
                   (32'(task_count_reg) > TASK_SLOTS) ? NW'(TASK_SLOTS) :
                   NW'(task_count_reg);

    assign m_ok  = 32'(obj_reg) < MUTEX_SLOTS;
    assign s_ok  = 32'(obj_reg) < SEMAPHORE_SLOTS;
    assign m_idx = MIDX'(obj_reg);
    assign s_idx = SIDX'(obj_reg);

    assign cand_ready = cell_state[cand_reg[TW-1:0]] == ST_READY;
    assign scan_last  = left_reg == NW'(1);
    assign sel_idx    = cand_ready ? cand_reg[TW-1:0] : running_reg;

    always_comb begin
        cmd   = '0;
        pass  = 1'b0;
        grant = 1'b0;
        if (state_reg == S_EXEC) begin
            case (op_reg)
                OP_TICK: begin
                    cmd.tick = 1'b1;
                    cmd.now  = counter_reg + 32'd1;
                    pass     = 1'b1;
                end
                OP_DELAY: begin
                    cmd.wake_wr  = 1'b1;
                    cmd.wake_val = counter_reg + dly_reg;
                    cmd.cur_wr   = 1'b1;
                    cmd.cur_val  = ST_BLOCKED;
                    pass         = 1'b1;
                end
                OP_LOCK: begin
                    if (m_ok) begin
                        if (locked_reg[m_idx] && owner_reg[m_idx] != OWN_W'(running_reg)) begin
                            cmd.cur_wr  = 1'b1;
                            cmd.cur_val = ST_MUTEX_WAIT;
                            pass        = 1'b1;
                        end else begin
                            grant = 1'b1;
                        end
                    end
                end
                OP_UNLOCK: begin
                    if (m_ok && owner_reg[m_idx] == OWN_W'(running_reg)) begin
                        cmd.unlock = 1'b1;
                    end
                end
                OP_WAIT: begin
                    if (s_ok) begin
                        if (sem_reg[s_idx] == 8'd0) begin
                            cmd.cur_wr  = 1'b1;
                            cmd.cur_val = ST_BLOCKED;
                            pass        = 1'b1;
                        end else begin
                            grant = 1'b1;
                        end
                    end
                end
                OP_POST: begin
                    if (s_ok) begin
                        cmd.post = 1'b1;
                    end
                end
                default: ;
            endcase
            cmd.release_cur = pass;
        end
        if (state_reg == S_SCAN) begin
            cmd.run = cand_ready || scan_last;
        end
    end

    assign blk_chain[0] = 1'b0;

    for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
        rrts_task_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .cmd           (cmd),
            .is_cur        (running_reg == TW'(i)),
            .is_sel        (sel_idx == TW'(i)),
            .active        (32'(n_eff) > i),
            .reset_running (i == 0),
            .blk_in        (blk_chain[i]),
            .blk_out       (blk_chain[i+1]),
            .state         (cell_state[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            task_count_reg <= 4'd1;
            counter_reg    <= '0;
            running_reg    <= '0;
            m_valid_reg    <= 1'b0;
            for (int m = 0; m < MUTEX_SLOTS; m++) begin
                locked_reg[m] <= 1'b0;
                owner_reg[m]  <= OWN_W'(NO_OWNER);
            end
            for (int s = 0; s < SEMAPHORE_SLOTS; s++) begin
                sem_reg[s] <= 8'd0;
            end
        end else begin
            if (cfg_wr_en) begin
                task_count_reg <= cfg_wr_data;
            end
            if (state_reg == S_DONE && (!m_valid_reg || m_axis_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        op_reg    <= s_axis_tdata[2:0];
                        dly_reg   <= s_axis_tdata[34:3];
                        obj_reg   <= s_axis_tdata[36:35];
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    sw_reg <= pass;
                    gr_reg <= grant;
                    if (cmd.tick) begin
                        counter_reg <= cmd.now;
                    end
                    if (op_reg == OP_LOCK && grant) begin
                        locked_reg[m_idx] <= 1'b1;
                        owner_reg[m_idx]  <= OWN_W'(running_reg);
                    end
                    if (cmd.unlock) begin
                        locked_reg[m_idx] <= 1'b0;
                        owner_reg[m_idx]  <= OWN_W'(NO_OWNER);
                    end
                    if (op_reg == OP_WAIT && grant) begin
                        sem_reg[s_idx] <= sem_reg[s_idx] - 8'd1;
                    end
                    if (cmd.post && sem_reg[s_idx] != SEM_MAX) begin
                        sem_reg[s_idx] <= sem_reg[s_idx] + 8'd1;
                    end
                    cand_reg  <= {1'b0, running_reg} + (TW+1)'(1);
                    state_reg <= pass ? S_MOD : S_DONE;
                end
                S_MOD: begin
                    // Bring the successor index below the task count.
                    if (cand_reg >= (TW+1)'(n_eff)) begin
                        cand_reg <= cand_reg - (TW+1)'(n_eff);
                    end else begin
                        left_reg  <= n_eff;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (cmd.run) begin
                        running_reg <= sel_idx;
                        state_reg   <= S_DONE;
                    end else begin
                        left_reg <= left_reg - NW'(1);
                        cand_reg <= (cand_reg + (TW+1)'(1) == (TW+1)'(n_eff)) ? '0 :
                                    cand_reg + (TW+1)'(1);
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_data_reg  <= {3'b000, gr_reg, sw_reg, 3'(running_reg)};
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
`default_nettype wire

// ----- rtl/rrts_task_cell.sv -----
// One task slot: its scheduling state and wake tick.
`default_nettype none
module rrts_task_cell
    import rrts_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cell_cmd_t   cmd,
    input  wire logic        is_cur,
    input  wire logic        is_sel,
    input  wire logic        active,
    input  wire logic        reset_running,
    input  wire logic        blk_in,
    output logic             blk_out,
    output task_state_t      state
);

    task_state_t state_reg, state_next;
    logic [31:0] wake_reg;

    always_comb begin
        state_next = state_reg;
        if (cmd.tick && active && state_reg == ST_BLOCKED && cmd.now >= wake_reg) begin
            state_next = ST_READY;
        end
        if (cmd.unlock && active && state_reg == ST_MUTEX_WAIT) begin
            state_next = ST_READY;
        end
        // Only the lowest blocked active task is woken by a post.
        if (cmd.post && active && state_reg == ST_BLOCKED && !blk_in) begin
            state_next = ST_READY;
        end
        if (is_cur && cmd.cur_wr) begin
            state_next = cmd.cur_val;
        end
        if (is_cur && cmd.release_cur && state_next == ST_RUNNING) begin
            state_next = ST_READY;
        end
        if (is_sel && cmd.run) begin
            state_next = ST_RUNNING;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= reset_running ? ST_RUNNING : ST_READY;
            wake_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (is_cur && cmd.wake_wr) begin
                wake_reg <= cmd.wake_val;
            end
        end
    end

    assign blk_out = blk_in | (active && state_reg == ST_BLOCKED);
    assign state   = state_reg;

endmodule
`default_nettype wire
